// ----- design/iptw_pkg.sv -----
// Shared types, timing tables and register map for the IDE PIO timing writer.
// No dependencies; compiled first.
package iptw_pkg;

  // Number of PIO modes in the timing table, and the fastest one.
  localparam int unsigned NUM_MODES = 4;
  localparam logic [1:0]  MAX_MODE  = 2'd3;

  // Active (t1) and recovery (t2) times in ns per PIO mode.
  localparam int unsigned ACT_NS_W = 10;
  localparam int unsigned REC_NS_W = 8;
  localparam logic [ACT_NS_W-1:0] ACT_NS [NUM_MODES] = '{10'd600, 10'd383, 10'd240, 10'd180};
  localparam logic [REC_NS_W-1:0] REC_NS [NUM_MODES] = '{8'd165, 8'd125, 8'd100, 8'd80};

  // Controller register numbers, one row per drive ({channel, unit}), one column per write.
  localparam int unsigned NUM_DRIVES = 4;
  localparam int unsigned NUM_WRITES = 4;
  localparam logic [7:0] REG_MAP [NUM_DRIVES][NUM_WRITES] = '{
    '{8'h03, 8'h26, 8'h04, 8'h27},
    '{8'h05, 8'h28, 8'h06, 8'h29},
    '{8'h2b, 8'h30, 8'h2c, 8'h31},
    '{8'h2d, 8'h32, 8'h2e, 8'h33}
  };

  // ns -> clocks: ceil(ns * mhz / 1000). The divide by 1000 is a multiply by
  // ceil(2^26 / 1000), exact for every 16-bit dividend.
  localparam int unsigned BUS_W       = 6;
  localparam int unsigned NS_MHZ_W    = 16;
  localparam logic [NS_MHZ_W-1:0] ROUND_UP = 16'd999;
  localparam int unsigned RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP = 17'd67109;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned CLK_W       = 6;   // ceil(999*63+999 / 1000) stays below 64

  // Slow modes (0..2) bump the second register pair by this many clocks.
  localparam logic [7:0] SLOW_OFFSET = 8'd8;

  // Configuration port.
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam logic        REG_BUS_SPEED = 1'b0;   // register index, paddr[2]
  localparam logic [BUS_W-1:0] BUS_SPEED_RST = 6'd50;

  // Default depth of the request queue between classifier and writer.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Beat number of a write within one request.
  typedef logic [1:0] beat_t;
  localparam beat_t LAST_BEAT = 2'd3;

  // One classified request, as queued for the writer.
  typedef struct packed {
    logic [ACT_NS_W-1:0] act_ns;
    logic [REC_NS_W-1:0] rec_ns;
    logic                slow;
    logic [1:0]          drv;
  } job_t;

endpackage

// ----- design/iptw_if.sv -----
// Valid/ready channel interfaces: tuning requests in, register writes out.
// No dependencies.
interface iptw_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pio_mode;
  logic        iordy_supported;
  logic [15:0] cycle_ns_with_iordy;
  logic [15:0] cycle_ns_plain;
  logic        channel;
  logic        unit;

  modport source (output valid, pio_mode, iordy_supported, cycle_ns_with_iordy,
                  cycle_ns_plain, channel, unit, input ready);
  modport sink   (input valid, pio_mode, iordy_supported, cycle_ns_with_iordy,
                  cycle_ns_plain, channel, unit, output ready);
endinterface

interface iptw_wr_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_index;
  logic [7:0] reg_value;
  logic       last_write;

  modport source (output valid, reg_index, reg_value, last_write, input ready);
  modport sink   (input valid, reg_index, reg_value, last_write, output ready);
endinterface

// ----- design/iptw_cfg.sv -----
// APB register block: holds the local bus speed used for ns -> clock conversion.
// Depends on iptw_pkg.
module iptw_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [iptw_pkg::PADDR_W-1:0]   paddr,
  input  logic [iptw_pkg::PDATA_W-1:0]   pwdata,
  output logic [iptw_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output logic [iptw_pkg::BUS_W-1:0]     bus_speed_o
);
  import iptw_pkg::*;

  logic [BUS_W-1:0] bus_speed_q, bus_speed_d;
  logic             sel_bus;

  assign sel_bus = (paddr[2] == REG_BUS_SPEED);
  assign pready  = 1'b1;

  always_comb begin
    bus_speed_d = bus_speed_q;
    if (psel && penable && pwrite && sel_bus) begin
      bus_speed_d = pwdata[BUS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_speed_q <= BUS_SPEED_RST;
    end else begin
      bus_speed_q <= bus_speed_d;
    end
  end

  assign prdata      = sel_bus ? {{(PDATA_W-BUS_W){1'b0}}, bus_speed_q} : '0;
  assign bus_speed_o = bus_speed_q;

endmodule

// ----- design/iptw_front.sv -----
// Request classifier: clamps the mode, picks t1/t2 from the table, takes a
// known, shorter drive cycle time in mode 3. Depends on iptw_pkg and iptw_if.
module iptw_front (
  iptw_req_if.sink            req,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output iptw_pkg::job_t      push_job_o
);
  import iptw_pkg::*;

  logic [1:0]          mode;
  logic [15:0]         drive_ns;
  logic [ACT_NS_W-1:0] act_ns;

  always_comb begin
    mode     = (req.pio_mode > {6'b0, MAX_MODE}) ? MAX_MODE : req.pio_mode[1:0];
    drive_ns = req.iordy_supported ? req.cycle_ns_with_iordy : req.cycle_ns_plain;
    act_ns   = ACT_NS[mode];
    // fast mode: a known, shorter drive cycle wins (it then fits the table width)
    if (mode == MAX_MODE && drive_ns != '0 && drive_ns < {6'b0, act_ns}) begin
      act_ns = drive_ns[ACT_NS_W-1:0];
    end
  end

  always_comb begin
    push_job_o.act_ns = act_ns;
    push_job_o.rec_ns = REC_NS[mode];
    push_job_o.slow   = (mode != MAX_MODE);
    push_job_o.drv    = {req.channel, req.unit};
  end

  assign push_valid_o = req.valid;
  assign req.ready    = push_ready_i;

endmodule

// ----- design/iptw_queue.sv -----
// Small request queue between classifier and register writer.
// Depends on iptw_pkg.
module iptw_queue #(
  parameter int unsigned Depth = iptw_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  iptw_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output iptw_pkg::job_t pop_job_o
);
  import iptw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");
  a_refuse_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_i && !push_ready_o |-> count_q == CntW'(Depth))
    else $error("queue refused a request while not full");
  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count did not drop on pop");
`endif

endmodule

// ----- design/iptw_back.sv -----
// Register writer: converts ns to bus clocks in two multiply stages, then
// issues the four register writes of a request. Depends on iptw_pkg, iptw_if.
module iptw_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [iptw_pkg::BUS_W-1:0]    bus_speed_i,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  iptw_pkg::job_t                pop_job_i,
  iptw_wr_if.source                     wr
);
  import iptw_pkg::*;

  localparam int unsigned ProdW = NS_MHZ_W + RECIP_W;

  // stage P: ns * MHz + 999
  logic                p_valid_q;
  logic [NS_MHZ_W-1:0] act_x_q, rec_x_q;
  logic                p_slow_q;
  logic [1:0]          p_drv_q;
  // stage Q: divided by 1000
  logic                q_valid_q;
  logic [CLK_W-1:0]    act_clk_q, rec_clk_q;
  logic                q_slow_q;
  logic [1:0]          q_drv_q;
  // issue stage
  logic                e_valid_q;
  logic [7:0]          val_q [NUM_WRITES];
  logic [1:0]          e_drv_q;
  beat_t               beat_q;

  logic                p_ready, q_ready, wr_fire;
  logic [ProdW-1:0]    act_prod, rec_prod;
  logic [7:0]          c2, c1, slow_add;

  assign wr_fire     = wr.valid && wr.ready;
  assign q_ready     = !e_valid_q || (wr_fire && beat_q == LAST_BEAT);
  assign p_ready     = !q_valid_q || q_ready;
  assign pop_ready_o = !p_valid_q || p_ready;

  assign act_prod = ProdW'(act_x_q) * ProdW'(RECIP);
  assign rec_prod = ProdW'(rec_x_q) * ProdW'(RECIP);

  assign c2       = {{(8-CLK_W){1'b0}}, rec_clk_q};
  assign c1       = {{(8-CLK_W){1'b0}}, act_clk_q} - c2;   // wraps mod 256
  assign slow_add = q_slow_q ? SLOW_OFFSET : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      q_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      beat_q    <= '0;
    end else begin
      if (pop_ready_o) begin
        p_valid_q <= pop_valid_i;
      end
      if (p_ready) begin
        q_valid_q <= p_valid_q;
      end
      if (q_ready) begin
        e_valid_q <= q_valid_q;
      end
      if (wr_fire) begin
        beat_q <= beat_q + 1'b1;   // wraps to zero after the last write
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      act_x_q  <= NS_MHZ_W'(pop_job_i.act_ns) * NS_MHZ_W'(bus_speed_i) + ROUND_UP;
      rec_x_q  <= NS_MHZ_W'(pop_job_i.rec_ns) * NS_MHZ_W'(bus_speed_i) + ROUND_UP;
      p_slow_q <= pop_job_i.slow;
      p_drv_q  <= pop_job_i.drv;
    end
    if (p_valid_q && p_ready) begin
      act_clk_q <= act_prod[RECIP_SHIFT +: CLK_W];
      rec_clk_q <= rec_prod[RECIP_SHIFT +: CLK_W];
      q_slow_q  <= p_slow_q;
      q_drv_q   <= p_drv_q;
    end
    if (q_valid_q && q_ready) begin
      val_q[0] <= c2;
      val_q[1] <= c1;
      val_q[2] <= c2 + slow_add;
      val_q[3] <= c1 + slow_add;
      e_drv_q  <= q_drv_q;
    end
  end

  assign wr.valid      = e_valid_q;
  assign wr.reg_index  = REG_MAP[e_drv_q][beat_q];
  assign wr.reg_value  = val_q[beat_q];
  assign wr.last_write = (beat_q == LAST_BEAT);

`ifndef SYNTHESIS
  a_load_at_first_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_q && q_ready |=> beat_q == '0)
    else $error("new request loaded mid-sequence");
  a_q_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_q && !q_ready |=> q_valid_q && $stable(act_clk_q) && $stable(rec_clk_q))
    else $error("converted counts lost while stalled");
  a_p_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && !p_ready |=> p_valid_q && $stable(act_x_q) && $stable(rec_x_q))
    else $error("scaled times lost while stalled");
  a_idle_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !e_valid_q |-> beat_q == '0)
    else $error("write beat not at start while idle");
`endif

endmodule

// ----- design/ide_pio_timing_register_writer.sv -----
// IDE PIO timing register writer, top level. Depends on iptw_pkg, iptw_if,
// iptw_cfg, iptw_front, iptw_queue and iptw_back.
// Each tuning request on req_i yields four register writes on wr_o: recovery
// count, active-minus-recovery count, then the same pair again (plus 8 more
// in modes 0..2), addressed from the per-drive register map; last_write marks
// the fourth. Modes above 3 run as mode 3, where a nonzero drive cycle time
// shorter than the table's active time replaces it. Counts are
// ceil(ns * bus_speed_mhz / 1000) and wrap to a byte. A request passes the
// classifier into a QueueDepth-entry queue, then two multiply stages, then the
// write issue stage. A request's four writes leave the single output port one
// per cycle while wr_o is ready, which bounds the sustained request rate; the
// queue and stages keep accepting requests while writes are still draining.
// bus_speed_mhz sits at APB byte address 0 (reset 50); change it only while
// no request is in flight.
module ide_pio_timing_register_writer #(
  parameter int unsigned QueueDepth = iptw_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [iptw_pkg::PADDR_W-1:0] paddr,
  input  logic [iptw_pkg::PDATA_W-1:0] pwdata,
  output logic [iptw_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  // tuning requests in, register writes out
  iptw_req_if.sink                     req_i,
  iptw_wr_if.source                    wr_o
);
  import iptw_pkg::*;

  logic [BUS_W-1:0] bus_speed;
  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  job_t             push_job, pop_job;

  iptw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .bus_speed_o (bus_speed)
  );

  // front: classify the request, no state
  iptw_front u_front (
    .req          (req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // decouples request acceptance from write issue
  iptw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // back: ns -> clocks, then four writes per request
  iptw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bus_speed_i (bus_speed),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .wr          (wr_o)
  );

endmodule

// ----- test/ide_pio_timing_register_writer_test.sv -----
// Testbench for ide_pio_timing_register_writer: drive-tuning requests in,
// four timing register writes out, each checked against an in-bench predictor.
// Depends on iptw_pkg, iptw_if and the block itself.
`timescale 1ns / 1ps

module ide_pio_timing_register_writer_test;

  import iptw_pkg::PADDR_W;
  import iptw_pkg::PDATA_W;
  import iptw_pkg::REG_BUS_SPEED;

  // Timing tables per PIO mode, kept here independently of the design package.
  localparam int unsigned ACTIVE_NS   [4] = '{600, 383, 240, 180};
  localparam int unsigned RECOVERY_NS [4] = '{165, 125, 100, 80};
  // Register numbers per drive {channel, unit}, in write order.
  localparam logic [7:0] DRIVE_REGS [4][4] = '{
    '{8'h03, 8'h26, 8'h04, 8'h27},
    '{8'h05, 8'h28, 8'h06, 8'h29},
    '{8'h2b, 8'h30, 8'h2c, 8'h31},
    '{8'h2d, 8'h32, 8'h2e, 8'h33}
  };
  localparam int unsigned FASTEST_MODE = 3;
  localparam int unsigned ROUND_UP     = 999;
  localparam int unsigned NS_PER_US    = 1000;
  localparam logic [7:0]  SLOW_BUMP    = 8'd8;
  localparam logic [5:0]  BUS_RESET    = 6'd50;

  localparam logic [PADDR_W-1:0] BUS_SPEED_ADDR = {REG_BUS_SPEED, 2'b00};

  // Run shape: one row per phase after the directed part.
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_BUS   [6] = '{25, 50, 33, 63, 0, 40};
  localparam int PHASE_IDLE  [6] = '{0, 77, 0, 31, 31, 0};
  localparam int PHASE_STALL [6] = '{0, 0, 77, 31, 31, 0};
  localparam int PRESSURE_PHASE  = 5;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 16;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [7:0]  pio_mode;
    logic        iordy_supported;
    logic [15:0] cycle_ns_with_iordy;
    logic [15:0] cycle_ns_plain;
    logic        channel;
    logic        unit;
  } tune_req_t;

  typedef struct packed {
    logic [7:0] reg_index;
    logic [7:0] reg_value;
    logic       last_write;
  } reg_write_t;

  // Predicts the register writes of each accepted request and checks the
  // writes coming out of the block against them, oldest first.
  class timing_write_board;
    logic [5:0]   bus_speed;
    reg_write_t   pending_writes[$];
    int unsigned  errors;
    int unsigned  requests_seen;
    int unsigned  writes_checked;

    function new();
      bus_speed      = BUS_RESET;
      errors         = 0;
      requests_seen  = 0;
      writes_checked = 0;
    endfunction

    function int unsigned ns_to_clocks(int unsigned ns);
      return (ns * int'(bus_speed) + ROUND_UP) / NS_PER_US;
    endfunction

    function void note_request(tune_req_t r);
      int unsigned mode;
      int unsigned act_ns;
      int unsigned drive_ns;
      logic [7:0]  rec_clk;
      logic [7:0]  act_clk;
      logic [7:0]  vals[4];
      reg_write_t  w;
      mode   = (r.pio_mode > FASTEST_MODE) ? FASTEST_MODE : int'(r.pio_mode);
      act_ns = ACTIVE_NS[mode];
      if (mode == FASTEST_MODE) begin
        // drive-reported cycle time only ever shortens the active time
        drive_ns = r.iordy_supported ? r.cycle_ns_with_iordy : r.cycle_ns_plain;
        if (drive_ns != 0 && drive_ns < act_ns) act_ns = drive_ns;
      end
      rec_clk = 8'(ns_to_clocks(RECOVERY_NS[mode]));
      act_clk = 8'(ns_to_clocks(act_ns) - rec_clk);   // wraps when short
      vals[0] = rec_clk;
      vals[1] = act_clk;
      vals[2] = rec_clk;
      vals[3] = act_clk;
      if (mode != FASTEST_MODE) begin
        vals[2] = vals[2] + SLOW_BUMP;
        vals[3] = vals[3] + SLOW_BUMP;
      end
      for (int k = 0; k < 4; k++) begin
        w.reg_index  = DRIVE_REGS[{r.channel, r.unit}][k];
        w.reg_value  = vals[k];
        w.last_write = (k == 3);
        pending_writes.push_back(w);
      end
      requests_seen++;
    endfunction

    function void check_write(reg_write_t got);
      reg_write_t want;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write index %h value %h last %b",
                 $time, got.reg_index, got.reg_value, got.last_write);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      writes_checked++;
      if (got.reg_index !== want.reg_index) begin
        $display("%0t: reg_index expected %h actual %h", $time, want.reg_index,
                 got.reg_index);
        errors++;
      end
      if (got.reg_value !== want.reg_value) begin
        $display("%0t: reg_value expected %h actual %h (index %h)", $time,
                 want.reg_value, got.reg_value, want.reg_index);
        errors++;
      end
      if (got.last_write !== want.last_write) begin
        $display("%0t: last_write expected %b actual %b (index %h)", $time,
                 want.last_write, got.last_write, want.reg_index);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  iptw_req_if req_if ();
  iptw_wr_if  wr_if ();

  ide_pio_timing_register_writer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .wr_o    (wr_if)
  );

  timing_write_board board;

  int          send_idle_pct;    // sender side, used by the main process only
  int          stall_pct;        // receiver side, set by NBA from main
  logic        hold_armed;       // main arms the long output hold-off once
  int          hold_count;       // counted by the receiver process alone
  int unsigned input_stalls;     // cycles a request waited during the hold-off
  int unsigned cycle_count;
  reg_write_t  seen_write;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes still pending", cycle_count,
               board.pending_writes.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output side: check every accepted write, then pick ready for the next cycle.
  // During the armed hold-off ready stays low so the request side backs up.
  always @(posedge clk_i) begin
    if (wr_if.valid === 1'b1 && wr_if.ready === 1'b1) begin
      seen_write.reg_index  = wr_if.reg_index;
      seen_write.reg_value  = wr_if.reg_value;
      seen_write.last_write = wr_if.last_write;
      board.check_write(seen_write);
    end
    if (hold_armed && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      if (req_if.valid && !req_if.ready) input_stalls <= input_stalls + 1;
      wr_if.ready <= 1'b0;
    end else begin
      wr_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic tune_req_t make_req(int mode, bit iordy, int cyc_iordy,
                                         int cyc_plain, bit chan, bit unit_sel);
    tune_req_t r;
    r.pio_mode            = 8'(mode);
    r.iordy_supported     = iordy;
    r.cycle_ns_with_iordy = 16'(cyc_iordy);
    r.cycle_ns_plain      = 16'(cyc_plain);
    r.channel             = chan;
    r.unit                = unit_sel;
    return r;
  endfunction

  // Cycle times cluster where they matter: unknown, tiny (count wraps), and
  // around the mode 3 active time; the rest spans the whole 16-bit field.
  function automatic int rand_cycle_ns();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 0;
    if (pick == 1) return $urandom_range(1, 10);
    if (pick <= 4) return $urandom_range(1, 600);
    return $urandom_range(65535);
  endfunction

  function automatic tune_req_t rand_req();
    int pick;
    int mode;
    pick = $urandom_range(9);
    if (pick <= 5)      mode = $urandom_range(3);
    else if (pick <= 7) mode = FASTEST_MODE;
    else                mode = $urandom_range(4, 255);
    return make_req(mode, $urandom_range(1), rand_cycle_ns(), rand_cycle_ns(),
                    $urandom_range(1), $urandom_range(1));
  endfunction

  // Offer one request after a random gap; valid stays up for a following one.
  task automatic send_request(input tune_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid               <= 1'b1;
    req_if.pio_mode            <= r.pio_mode;
    req_if.iordy_supported     <= r.iordy_supported;
    req_if.cycle_ns_with_iordy <= r.cycle_ns_with_iordy;
    req_if.cycle_ns_plain      <= r.cycle_ns_plain;
    req_if.channel             <= r.channel;
    req_if.unit                <= r.unit;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    board.note_request(r);
  endtask

  // Stop offering and wait until every predicted write has come out.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (board.pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr,
                           input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read_check(input logic [PADDR_W-1:0] addr,
                                input logic [PDATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t: prdata at %h expected %h actual %h", $time, addr, want, prdata);
      board.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the bus speed, updates the predictor, idles the bus, then reads the value back.
  task automatic set_bus_speed(input int mhz);
    cfg_write(BUS_SPEED_ADDR, PDATA_W'(mhz));
    board.bus_speed = 6'(mhz);
    @(posedge clk_i);
    cfg_read_check(BUS_SPEED_ADDR, PDATA_W'(mhz));
  endtask

  // Directed part at the reset bus speed: every mode including ones above 3,
  // all four drives, cycle-time edges around 180 ns, unknown cycle times,
  // a 1 ns cycle that makes the second count wrap, and field extremes.
  task automatic run_directed();
    send_request(make_req(0, 0, 0, 0, 0, 0));
    send_request(make_req(1, 1, 16'hFFFF, 16'hFFFF, 0, 1));
    send_request(make_req(2, 0, 0, 0, 1, 0));
    send_request(make_req(3, 0, 0, 0, 1, 1));
    send_request(make_req(3, 1, 1, 16'hFFFF, 0, 0));
    send_request(make_req(3, 0, 16'hFFFF, 1, 0, 1));
    send_request(make_req(3, 1, 179, 0, 1, 0));
    send_request(make_req(3, 1, 180, 0, 1, 1));
    send_request(make_req(3, 0, 0, 181, 0, 0));
    send_request(make_req(3, 1, 0, 100, 0, 1));
    send_request(make_req(4, 1, 120, 0, 1, 0));
    send_request(make_req(254, 0, 0, 90, 1, 1));
    send_request(make_req(255, 1, 150, 150, 0, 0));
    send_request(make_req(8'h80, 0, 0, 0, 0, 1));
    send_request(make_req(2, 1, 1, 1, 1, 1));
    send_request(make_req(1, 0, 16'hAAAA, 16'h5555, 1, 0));
    send_request(make_req(0, 1, 16'h5555, 16'hAAAA, 0, 0));
    send_request(make_req(3, 1, 16'h8000, 16'h0001, 1, 1));
    drain();
  endtask

  initial begin
    board = new();
    rst_ni                     = 1'b0;
    psel                       = 1'b0;
    penable                    = 1'b0;
    pwrite                     = 1'b0;
    paddr                      = '0;
    pwdata                     = '0;
    req_if.valid               = 1'b0;
    req_if.pio_mode            = '0;
    req_if.iordy_supported     = 1'b0;
    req_if.cycle_ns_with_iordy = '0;
    req_if.cycle_ns_plain      = '0;
    req_if.channel             = 1'b0;
    req_if.unit                = 1'b0;
    wr_if.ready                = 1'b0;
    send_idle_pct              = 0;
    stall_pct                  = 0;
    hold_armed                 = 1'b0;
    hold_count                 = 0;
    input_stalls               = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset value of the bus speed, then the directed requests at that speed
    cfg_read_check(BUS_SPEED_ADDR, PDATA_W'(BUS_RESET));
    run_directed();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_bus_speed(PHASE_BUS[p]);
      send_idle_pct = PHASE_IDLE[p];
      stall_pct    <= PHASE_STALL[p];
      // long hold-off on the write side while requests keep coming
      if (p == PRESSURE_PHASE) hold_armed <= 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_request(rand_req());
      drain();
    end

    $display("covered %0d requests and %0d register writes over %0d bus speeds,",
             board.requests_seen, board.writes_checked, NUM_PHASES + 1);
    $display("mixed idle/stall rates and a %0d-cycle write hold-off (%0d input stalls)",
             HOLD_CYCLES, input_stalls);
    if (board.errors == 0 && board.pending_writes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d errors, %0d writes never seen", board.errors,
               board.pending_writes.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- ide_pio_timing_register_writer.f -----
design/iptw_pkg.sv
design/iptw_if.sv
design/iptw_cfg.sv
design/iptw_front.sv
design/iptw_queue.sv
design/iptw_back.sv
design/ide_pio_timing_register_writer.sv
test/ide_pio_timing_register_writer_test.sv
